### sv/sgp_pkg.sv
package sgp_pkg;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
  } pix_out_t;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgTargetHue = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHueSpread = 2'd1;

  localparam logic [8:0] TargetHueReset = 9'd40;
  localparam logic [8:0] HueSpreadReset = 9'd30;

  localparam int LumW = 24;
  localparam int WgtW = 17;
  localparam logic [WgtW-1:0] WOne = 17'd65536;
  localparam logic [15:0] CoefR = 16'd13933;
  localparam logic [15:0] CoefG = 16'd46871;
  localparam logic [15:0] CoefB = 16'd4732;

  localparam int HueNumW = 17;
  localparam int HueQuoW = 9;
  localparam int WgtNumW = 25;
  localparam int DefHueStepsPerStage = 3;
  localparam int DefWgtStepsPerStage = 3;

  typedef struct packed {
    pix_in_t          pix;
    logic [LumW-1:0]  lum;
  } hue_sb_t;

  typedef struct packed {
    pix_in_t          pix;
    logic [LumW-1:0]  lum;
    logic             full;
    logic             zero;
  } wgt_sb_t;

endpackage

### sv/sgp_front.sv
module sgp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  sgp_pkg::pix_in_t            pix_i,
  output logic                        valid_o,
  output logic [sgp_pkg::HueNumW-1:0] num_o,
  output logic [7:0]                  den_o,
  output sgp_pkg::hue_sb_t            sb_o
);
  import sgp_pkg::*;

  logic [7:0]         mx, mn, dd;
  logic signed [19:0] sr, sg, sb, sd, num_s;
  logic [HueNumW-1:0] num_d;
  logic [7:0]         den_d;
  logic [LumW-1:0]    lum_d;
  logic               valid_q;
  logic [HueNumW-1:0] num_q;
  logic [7:0]         den_q;
  hue_sb_t            sb_q;

  always_comb begin
    mx = pix_i.red_in;
    mn = pix_i.red_in;
    if (pix_i.green_in > mx) mx = pix_i.green_in;
    if (pix_i.blue_in > mx) mx = pix_i.blue_in;
    if (pix_i.green_in < mn) mn = pix_i.green_in;
    if (pix_i.blue_in < mn) mn = pix_i.blue_in;
    dd = mx - mn;
    sr = 20'(pix_i.red_in);
    sg = 20'(pix_i.green_in);
    sb = 20'(pix_i.blue_in);
    sd = 20'(dd);
    if (mx == pix_i.red_in) begin
      num_s = 20'sd60 * (sg - sb);
    end else if (mx == pix_i.green_in) begin
      num_s = 20'sd120 * sd + 20'sd60 * (sb - sr);
    end else begin
      num_s = 20'sd240 * sd + 20'sd60 * (sr - sg);
    end
    if (num_s < 0) num_s = num_s + 20'sd360 * sd;
    if (dd == 8'd0) begin
      num_d = '0;
      den_d = 8'd1;
    end else begin
      num_d = num_s[HueNumW-1:0];
      den_d = dd;
    end
    lum_d = LumW'(LumW'(CoefR) * LumW'(pix_i.red_in))
          + LumW'(LumW'(CoefG) * LumW'(pix_i.green_in))
          + LumW'(LumW'(CoefB) * LumW'(pix_i.blue_in));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      num_q      <= num_d;
      den_q      <= den_d;
      sb_q.pix   <= pix_i;
      sb_q.lum   <= lum_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign sb_o    = sb_q;
endmodule

### sv/sgp_div.sv
module sgp_div #(
  parameter int NW  = 17,
  parameter int DW  = 8,
  parameter int QW  = 9,
  parameter int SPS = 3,
  parameter int SBW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [QW-1:0]  quo_o,
  output logic [SBW-1:0] sb_o
);
  localparam int NS = (QW + SPS - 1) / SPS;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0]  rem_q [NS+1];
  logic [QW-1:0]  quo_q [NS+1];
  logic [DW-1:0]  den_q [NS+1];
  logic [SBW-1:0] sb_q  [NS+1];
  logic           vld_q [NS+1];

  assign rem_q[0] = CW'(num_i);
  assign quo_q[0] = '0;
  assign den_q[0] = den_i;
  assign sb_q[0]  = sb_i;
  assign vld_q[0] = valid_i;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [CW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin : p_step
      int            bi;
      logic [CW-1:0] sub;
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      for (int s = 0; s < SPS; s++) begin
        bi = QW - 1 - (k * SPS + s);
        if (bi >= 0) begin
          sub = CW'(den_q[k]) << bi;
          if (rem_d >= sub) begin
            rem_d     = rem_d - sub;
            quo_d[bi] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= quo_d;
        den_q[k+1] <= den_q[k];
        sb_q[k+1]  <= sb_q[k];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign quo_o   = quo_q[NS];
  assign sb_o    = sb_q[NS];
endmodule

### sv/sgp_blend.sv
module sgp_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  sgp_pkg::pix_in_t          pix_i,
  input  logic [sgp_pkg::LumW-1:0]  lum_i,
  input  logic [sgp_pkg::WgtW-1:0]  wgt_i,
  output logic                      valid_o,
  output sgp_pkg::pix_out_t         pix_o
);
  import sgp_pkg::*;

  logic [4:0]            vld_q;
  logic [2:0][7:0]       ch;
  logic [WgtW-1:0]       omw;
  logic [2:0][24:0]      k_d, k_q;
  logic [31:0]           al_d, al_q;
  logic [25:0]           asum;
  logic [7:0]            a_d, a1_q, a2_q, a3_q, a4_q;
  logic [WgtW-1:0]       w1_q;
  logic [2:0][32:0]      kk_d, kk_q;
  logic [48:0]           gp_d, gp_q;
  logic [2:0][17:0]      y_d, y_q, y4_q;
  logic [2:0][10:0]      q_d, q_q;
  logic [2:0][26:0]      prod;
  logic [2:0][49:0]      x;
  logic [2:0][17:0]      rr;
  logic [2:0][10:0]      qc;
  pix_out_t              out_d, out_q;

  assign ch[0] = pix_i.red_in;
  assign ch[1] = pix_i.green_in;
  assign ch[2] = pix_i.blue_in;

  always_comb begin
    omw  = WOne - wgt_i;
    for (int c = 0; c < 3; c++) k_d[c] = 25'(ch[c]) * 25'(omw);
    al_d = 32'(pix_i.alpha_in) * 32'(lum_i);
    asum = 26'(26'(pix_i.alpha_in) * 26'(omw)) + 26'(26'd255 * 26'(wgt_i));
    a_d  = (asum[25:16] > 10'd255) ? 8'd255 : asum[23:16];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) kk_d[c] = 33'(k_q[c]) * 33'd255;
    gp_d = 49'(al_q) * 49'(w1_q);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      x[c]   = 50'({kk_q[c], 16'h0000}) + 50'(gp_q);
      y_d[c] = x[c][49:32];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = 27'(y_q[c]) * 27'd257;
      q_d[c]  = prod[c][26:16];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rr[c] = y4_q[c] - 18'(18'(q_q[c]) * 18'd255);
      qc[c] = (rr[c] >= 18'd255) ? q_q[c] + 11'd1 : q_q[c];
    end
    out_d.red_out   = (qc[0] > 11'd255) ? 8'd255 : qc[0][7:0];
    out_d.green_out = (qc[1] > 11'd255) ? 8'd255 : qc[1][7:0];
    out_d.blue_out  = (qc[2] > 11'd255) ? 8'd255 : qc[2][7:0];
    out_d.alpha_out = a4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      k_q   <= k_d;
      al_q  <= al_d;
      w1_q  <= wgt_i;
      a1_q  <= a_d;
      kk_q  <= kk_d;
      gp_q  <= gp_d;
      a2_q  <= a1_q;
      y_q   <= y_d;
      a3_q  <= a2_q;
      q_q   <= q_d;
      y4_q  <= y_q;
      a4_q  <= a3_q;
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[4];
  assign pix_o   = out_q;
endmodule

### sv/selective_grayscale_pixel_core.sv
// Selective desaturation by hue for RGBA8 pixels. The core takes one pixel per cycle and
// returns one pixel per cycle while the output is not stalled; a pixel passes through
// one front stage, ceil(9/HueStepsPerStage) hue divider stages, one weight select stage,
// ceil(17/WgtStepsPerStage) weight divider stages and five blend stages. The whole pipeline
// advances together whenever the output register is empty or its request is taken, so
// in_ready_o follows out_ready_i. Write target_hue and hue_spread only while no pixel is
// in flight.
module selective_grayscale_pixel_core #(
  parameter int HueStepsPerStage = sgp_pkg::DefHueStepsPerStage,
  parameter int WgtStepsPerStage = sgp_pkg::DefWgtStepsPerStage
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sgp_pkg::pix_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sgp_pkg::pix_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sgp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [8:0]                   cfg_data_i
);
  import sgp_pkg::*;

  logic               adv;
  logic [8:0]         target_q, spread_q;
  logic               f_valid;
  logic [HueNumW-1:0] f_num;
  logic [7:0]         f_den;
  hue_sb_t            f_sb, h_sb;
  logic               h_valid;
  logic [HueQuoW-1:0] h_quo;
  logic [8:0]         diff;
  logic               s_valid_q;
  logic [WgtNumW-1:0] s_num_q;
  logic [8:0]         s_den_q;
  wgt_sb_t            s_sb_d, s_sb_q, w_sb;
  logic               w_valid;
  logic [WgtW-1:0]    w_quo, wgt;
  logic               b_valid;

  assign adv         = !b_valid || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = b_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetHueReset;
      spread_q <= HueSpreadReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgTargetHue) target_q <= cfg_data_i;
      if (cfg_index_i == CfgHueSpread) spread_q <= cfg_data_i;
    end
  end

  sgp_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i), .pix_i(in_data_i),
    .valid_o(f_valid), .num_o(f_num), .den_o(f_den), .sb_o(f_sb)
  );

  sgp_div #(
    .NW(HueNumW), .DW(8), .QW(HueQuoW), .SPS(HueStepsPerStage), .SBW($bits(hue_sb_t))
  ) u_hue_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(f_valid), .num_i(f_num), .den_i(f_den),
    .sb_i(f_sb), .valid_o(h_valid), .quo_o(h_quo), .sb_o(h_sb)
  );

  always_comb begin
    diff = (target_q >= h_quo) ? target_q - h_quo : h_quo - target_q;
    s_sb_d.pix = h_sb.pix;
    s_sb_d.lum = h_sb.lum;
    if (spread_q == 9'd0) begin
      s_sb_d.full = (diff != 9'd0);
      s_sb_d.zero = (diff == 9'd0);
    end else begin
      s_sb_d.full = (diff > spread_q);
      s_sb_d.zero = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (adv) begin
      s_valid_q <= h_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_num_q <= {diff, 16'h0000};
      s_den_q <= spread_q;
      s_sb_q  <= s_sb_d;
    end
  end

  sgp_div #(
    .NW(WgtNumW), .DW(9), .QW(WgtW), .SPS(WgtStepsPerStage), .SBW($bits(wgt_sb_t))
  ) u_wgt_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s_valid_q), .num_i(s_num_q), .den_i(s_den_q),
    .sb_i(s_sb_q), .valid_o(w_valid), .quo_o(w_quo), .sb_o(w_sb)
  );

  assign wgt = w_sb.full ? WOne : (w_sb.zero ? '0 : w_quo);

  sgp_blend u_blend (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(w_valid), .pix_i(w_sb.pix), .lum_i(w_sb.lum),
    .wgt_i(wgt), .valid_o(b_valid), .pix_o(out_data_o)
  );
endmodule

### dv/tb_selective_grayscale_pixel_core.sv
`timescale 1ns / 1ps

module tb_selective_grayscale_pixel_core;
  import sgp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;

  int unsigned target_hue_q = TargetHueReset;
  int unsigned hue_spread_q = HueSpreadReset;
  pix_out_t blended_pixels[$];
  int n_errors = 0;
  int n_pixels = 0;
  int n_results = 0;
  int stall_hold = 0;
  bit use_gaps = 1'b1;

  always #1 clk_i = ~clk_i;

  selective_grayscale_pixel_core dut (.*);

  function automatic int unsigned hue_deg(int unsigned r, int unsigned g, int unsigned b);
    int unsigned mx, mn, d;
    int num;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) return 0;
    if (mx == r) num = 60 * (int'(g) - int'(b));
    else if (mx == g) num = 120 * int'(d) + 60 * (int'(b) - int'(r));
    else num = 240 * int'(d) + 60 * (int'(r) - int'(g));
    if (num < 0) num += 360 * int'(d);
    return int'(num) / d;
  endfunction

  function automatic logic [7:0] clip8(longint unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pix_out_t desaturate(pix_in_t p);
    pix_out_t o;
    int unsigned h, diff;
    longint unsigned w, lum, gray, keep;
    longint unsigned ch[3];
    h = hue_deg(p.red_in, p.green_in, p.blue_in);
    diff = (target_hue_q > h) ? target_hue_q - h : h - target_hue_q;
    if (hue_spread_q == 0) w = (diff == 0) ? 0 : 65536;
    else if (diff <= hue_spread_q) w = (longint'(diff) << 16) / hue_spread_q;
    else w = 65536;
    lum = 64'd13933 * p.red_in + 64'd46871 * p.green_in + 64'd4732 * p.blue_in;
    gray = longint'(p.alpha_in) * lum * w;
    ch[0] = p.red_in; ch[1] = p.green_in; ch[2] = p.blue_in;
    for (int i = 0; i < 3; i++) begin
      keep = ch[i] * (65536 - w) * 255 * 65536;
      ch[i] = (keep + gray) / (64'd255 << 32);
    end
    o.red_out = clip8(ch[0]);
    o.green_out = clip8(ch[1]);
    o.blue_out = clip8(ch[2]);
    o.alpha_out = clip8((longint'(p.alpha_in) * (65536 - w) + 255 * w) >> 16);
    return o;
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    int gap;
    gap = use_gaps ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{red_in: r, green_in: g, blue_in: b, alpha_in: a};
    do @(posedge clk_i); while (!in_ready_o);
    blended_pixels.push_back(desaturate(in_data_i));
    n_pixels++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (blended_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [8:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTargetHue) target_hue_q = val;
    else hue_spread_q = val;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (blended_pixels.size() == 0) begin
        $error("unexpected result %h", out_data_o);
        n_errors++;
      end else begin
        pix_out_t e;
        e = blended_pixels.pop_front();
        n_results++;
        if (out_data_o.red_out !== e.red_out) begin
          $error("red_out expected %0d actual %0d", e.red_out, out_data_o.red_out);
          n_errors++;
        end
        if (out_data_o.green_out !== e.green_out) begin
          $error("green_out expected %0d actual %0d", e.green_out, out_data_o.green_out);
          n_errors++;
        end
        if (out_data_o.blue_out !== e.blue_out) begin
          $error("blue_out expected %0d actual %0d", e.blue_out, out_data_o.blue_out);
          n_errors++;
        end
        if (out_data_o.alpha_out !== e.alpha_out) begin
          $error("alpha_out expected %0d actual %0d", e.alpha_out, out_data_o.alpha_out);
          n_errors++;
        end
      end
    end
  end

  // The receiver stalls per request, or for one long stretch on demand.
  initial begin
    int wait_cycles;
    forever begin
      if (stall_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall_hold) @(posedge clk_i);
        stall_hold = 0;
      end
      if (use_gaps) begin
        wait_cycles = $urandom_range(15, 0);
        if (wait_cycles > 0) begin
          out_ready_i <= 1'b0;
          repeat (wait_cycles) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i) && stall_hold == 0);
    end
  end

  task automatic test_directed;
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 255);
    send_pixel(128, 128, 128, 200);
    send_pixel(255, 0, 0, 255);
    send_pixel(0, 255, 0, 255);
    send_pixel(0, 0, 255, 255);
    send_pixel(255, 255, 0, 128);
    send_pixel(0, 255, 255, 64);
    send_pixel(255, 0, 255, 1);
    send_pixel(255, 170, 0, 255);
    send_pixel(255, 0, 1, 255);
    send_pixel(200, 150, 10, 0);
    send_pixel(10, 20, 30, 255);
    send_pixel(170, 85, 0, 255);
    drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_settings;
    logic [8:0] targets[5] = '{9'd0, 9'd359, 9'd511, 9'd180, 9'd60};
    logic [8:0] spreads[5] = '{9'd1, 9'd360, 9'd0, 9'd511, 9'd90};
    for (int k = 0; k < 5; k++) begin
      write_reg(CfgTargetHue, targets[k]);
      write_reg(CfgHueSpread, spreads[k]);
      send_pixel(255, 0, 0, 255);
      send_pixel(0, 0, 255, 255);
      test_random(120);
      drain();
    end
    write_reg(CfgTargetHue, 9'($urandom_range(359, 0)));
    write_reg(CfgHueSpread, 9'($urandom_range(360, 1)));
    use_gaps = 1'b0;
    test_random(60);
    use_gaps = 1'b1;
    drain();
  endtask

  task automatic test_backpressure;
    use_gaps = 1'b0;
    stall_hold = 200;
    test_random(100);
    use_gaps = 1'b1;
    test_random(100);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(60);
    drain();
    test_settings();
    test_backpressure();
    $display("Sent %0d pixels and checked %0d results over several hue settings.",
             n_pixels, n_results);
    if (n_errors == 0 && blended_pixels.size() == 0) begin
      $display("selective_grayscale_pixel_core verification clean");
    end else begin
      $display("selective_grayscale_pixel_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("selective_grayscale_pixel_core verification failed");
    $finish;
  end
endmodule
